[hw/rtl/rldt_pkg.sv]
// types and codes shared by the ring log durability tracker
// no dependencies; imported by every rtl module of the block
package rldt_pkg;

   localparam logic [31:0] CapacityReset = 32'd65536;

   typedef enum logic [2:0] {
      OP_MOUNT    = 3'd0,
      OP_BATCH    = 3'd1,
      OP_META     = 3'd2,
      OP_TERMINAL = 3'd3,
      OP_QUERY    = 3'd4,
      OP_PLAN     = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_INVALID    = 3'd1,
      ST_RANGE      = 3'd2,
      ST_BUSY       = 3'd3,
      ST_WRITE_FAIL = 3'd4,
      ST_META_FAIL  = 3'd5
   } status_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [63:0] cand_read_seq;
      logic [63:0] cand_write_seq;
      logic [63:0] cand_dropped;
      logic [63:0] batch_first_seq;
      logic        sync_asked;
      logic        write_ok;
      logic        metadata_ok;
      logic        quarantined;
      logic [63:0] plan_first_seq;
      logic [31:0] plan_limit;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] shown_read_seq;
      logic [63:0] shown_write_seq;
      logic [63:0] shown_dropped;
      logic [63:0] unsafe_count;
      logic [31:0] plan_count;
      logic        terminal_flag;
   } rsp_type;

   // durable state of the ring log cursor
   typedef struct packed {
      logic [63:0] head_seq;
      logic [63:0] tail_seq;
      logic [63:0] dropped;
      logic [63:0] unsafe_start;
      logic        unsafe_mark;
      logic        terminal_mark;
   } cursor_type;

   // word leaving the update stage
   typedef struct packed {
      opcode_type  opcode;
      status_type  status;
      logic [63:0] plan_first_seq;
      logic [31:0] plan_limit;
   } upd_type;

   // word leaving the advertise stage
   typedef struct packed {
      opcode_type  opcode;
      status_type  status;
      logic [63:0] head_seq;
      logic [63:0] tail_seq;
      logic [63:0] dropped;
      logic [63:0] hidden;
      logic        terminal_mark;
      logic [63:0] plan_first_seq;
      logic [31:0] plan_limit;
   } shown_type;

endpackage

[hw/rtl/ring_log_durability_tracker.sv]
// channel | dir | handshake           | word
// req     | in  | req_valid/req_ready | req_data (req_type), one command
// rsp     | out | rsp_valid/rsp_ready | rsp_data (rsp_type), one per command
// csr     | in  | csr_valid/csr_ready | csr_data, ring capacity in packets
//
// one command per cycle sustained while rsp_ready holds; a response passes through
// input register, cursor update, advertised cursor, read plan / response.
// each stage holds its word and only moves when the next one is free.
// synchronous reset clears the cursor, the marks and capacity to 65536.
// depends on rldt_pkg and the three rldt stage modules
module ring_log_durability_tracker
   import rldt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic       cmd_valid_ff;
   req_type    cmd_ff;
   logic       upd_valid_ff;
   logic       shown_valid_ff;
   logic       rsp_valid_ff;
   logic       upd_load;
   logic       shown_load;
   logic       rsp_load;
   cursor_type cursor;
   upd_type    upd;
   shown_type  shown;

   // each stage loads when the stage below it is empty or emptying
   assign rsp_load   = shown_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign shown_load = upd_valid_ff && (!shown_valid_ff || rsp_load);
   assign upd_load   = cmd_valid_ff && (!upd_valid_ff || shown_load);
   assign req_ready  = !cmd_valid_ff || upd_load;
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff   <= 1'b0;
         upd_valid_ff   <= 1'b0;
         shown_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_ready) begin
            cmd_valid_ff <= req_valid;
         end
         if (!upd_valid_ff || shown_load) begin
            upd_valid_ff <= upd_load;
         end
         if (!shown_valid_ff || rsp_load) begin
            shown_valid_ff <= shown_load;
         end
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= rsp_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_data;
      end
   end

   rldt_cursor_update u_update (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .load      (upd_load),
      .cmd       (cmd_ff),
      .cursor_ff (cursor),
      .upd_ff    (upd)
   );

   // reads the cursor left by the word it carries, the newest one applied
   rldt_shown_cursor u_shown (
      .clock    (clock),
      .load     (shown_load),
      .cursor   (cursor),
      .upd      (upd),
      .shown_ff (shown)
   );

   rldt_read_plan u_plan (
      .clock  (clock),
      .load   (rsp_load),
      .shown  (shown),
      .rsp_ff (rsp_data)
   );

`ifndef SYNTHESIS
   a_cmd_holds: assert property (@(posedge clock) disable iff (reset)
      cmd_valid_ff && !upd_load |=> cmd_valid_ff && $stable(cmd_ff))
      else $error("input word lost while stalled");
   a_upd_holds: assert property (@(posedge clock) disable iff (reset)
      upd_valid_ff && !shown_load |=> upd_valid_ff && $stable(upd))
      else $error("update word lost while stalled");
   a_shown_holds: assert property (@(posedge clock) disable iff (reset)
      shown_valid_ff && !rsp_load |=> shown_valid_ff && $stable(shown))
      else $error("advertised word lost while stalled");
   a_range_no_plan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data.status == ST_RANGE |-> rsp_data.plan_count == '0)
      else $error("out of range plan with a count");
`endif

endmodule

[hw/rtl/rldt_cursor_update.sv]
// command decode and durable cursor state with the ring capacity register
// depends on rldt_pkg
module rldt_cursor_update
   import rldt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   input  logic        load,
   input  req_type     cmd,
   output cursor_type  cursor_ff,
   output upd_type     upd_ff
);

   logic [31:0] capacity_ff;
   cursor_type  cursor_in;
   upd_type     upd_in;
   logic        cand_ok;
   logic        floor_up;
   logic [63:0] cand_span;

   assign csr_ready = 1'b1;
   assign cand_span = cmd.cand_write_seq - cmd.cand_read_seq;
   assign cand_ok   = (cmd.cand_write_seq >= cmd.cand_read_seq) &&
                      (cand_span <= {32'd0, capacity_ff});
   assign floor_up  = cmd.cand_read_seq > cursor_ff.head_seq;

   always_comb begin
      cursor_in             = cursor_ff;
      upd_in.opcode         = cmd.opcode;
      upd_in.status         = ST_OK;
      upd_in.plan_first_seq = cmd.plan_first_seq;
      upd_in.plan_limit     = cmd.plan_limit;
      unique case (cmd.opcode)
         OP_MOUNT: begin
            if (!cand_ok) begin
               upd_in.status = ST_INVALID;
            end else begin
               cursor_in.head_seq      = cmd.cand_read_seq;
               cursor_in.tail_seq      = cmd.cand_write_seq;
               cursor_in.dropped       = cmd.cand_dropped;
               cursor_in.unsafe_start  = '0;
               cursor_in.unsafe_mark   = 1'b0;
               cursor_in.terminal_mark = 1'b0;
            end
         end
         OP_BATCH: begin
            if (!cand_ok || (cmd.batch_first_seq > cmd.cand_write_seq)) begin
               upd_in.status = ST_INVALID;
            end else if (!cmd.write_ok) begin
               // tail from the batch start is no longer trusted
               if (cmd.batch_first_seq < cursor_ff.tail_seq) begin
                  cursor_in.unsafe_start = cmd.batch_first_seq;
                  cursor_in.unsafe_mark  = 1'b1;
               end
               if (floor_up) begin
                  cursor_in.head_seq = cmd.cand_read_seq;
                  cursor_in.dropped  = cmd.cand_dropped;
               end
               upd_in.status = ST_WRITE_FAIL;
            end else begin
               cursor_in.unsafe_mark  = 1'b0;
               cursor_in.unsafe_start = '0;
               if (cmd.metadata_ok) begin
                  cursor_in.head_seq = cmd.cand_read_seq;
                  cursor_in.tail_seq = cmd.cand_write_seq;
                  cursor_in.dropped  = cmd.cand_dropped;
               end else begin
                  if (floor_up) begin
                     cursor_in.head_seq = cmd.cand_read_seq;
                     cursor_in.dropped  = cmd.cand_dropped;
                  end
                  upd_in.status = ST_META_FAIL;
               end
            end
         end
         OP_META: begin
            if (cmd.quarantined) begin
               upd_in.status = ST_BUSY;
            end else if (!cand_ok) begin
               upd_in.status = ST_INVALID;
            end else if (!cmd.metadata_ok) begin
               upd_in.status = ST_META_FAIL;
            end else begin
               cursor_in.head_seq = cmd.cand_read_seq;
               cursor_in.tail_seq = cmd.cand_write_seq;
               cursor_in.dropped  = cmd.cand_dropped;
            end
         end
         OP_TERMINAL: begin
            cursor_in.terminal_mark = 1'b1;
         end
         OP_QUERY, OP_PLAN: begin
            upd_in.status = ST_OK;
         end
         default: begin
            upd_in.status = ST_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapacityReset;
         cursor_ff   <= '0;
      end else begin
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
         if (load) begin
            cursor_ff <= cursor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         upd_ff <= upd_in;
      end
   end

`ifndef SYNTHESIS
   a_mount_clears: assert property (@(posedge clock) disable iff (reset)
      load && cmd.opcode == OP_MOUNT && cand_ok
      |=> !cursor_ff.unsafe_mark && !cursor_ff.terminal_mark)
      else $error("mount left a mark set");
   a_refused_keeps: assert property (@(posedge clock) disable iff (reset)
      load && upd_in.status == ST_INVALID |=> $stable(cursor_ff))
      else $error("refused command changed the cursor");
   a_idle_keeps: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(cursor_ff))
      else $error("cursor changed without a command");
`endif

endmodule

[hw/rtl/rldt_shown_cursor.sv]
// advertised cursor: write end clamped to the unsafe start, hidden packets
// added to the drop count with saturation; depends on rldt_pkg
module rldt_shown_cursor
   import rldt_pkg::*;
(
   input  logic       clock,
   input  logic       load,
   input  cursor_type cursor,
   input  upd_type    upd,
   output shown_type  shown_ff
);

   shown_type   shown_in;
   logic [63:0] safe;
   logic [63:0] hidden;
   logic [64:0] drop_sum;

   always_comb begin
      safe = cursor.unsafe_start;
      if (cursor.unsafe_start < cursor.head_seq) begin
         safe = cursor.head_seq;
      end else if (cursor.unsafe_start > cursor.tail_seq) begin
         safe = cursor.tail_seq;
      end
      hidden   = cursor.unsafe_mark ? (cursor.tail_seq - safe) : '0;
      drop_sum = {1'b0, cursor.dropped} + {1'b0, hidden};

      shown_in.opcode         = upd.opcode;
      shown_in.status         = upd.status;
      shown_in.head_seq       = cursor.head_seq;
      shown_in.tail_seq       = cursor.unsafe_mark ? safe : cursor.tail_seq;
      shown_in.dropped        = drop_sum[64] ? '1 : drop_sum[63:0];
      shown_in.hidden         = hidden;
      shown_in.terminal_mark  = cursor.terminal_mark;
      shown_in.plan_first_seq = upd.plan_first_seq;
      shown_in.plan_limit     = upd.plan_limit;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         shown_ff <= shown_in;
      end
   end

endmodule

[hw/rtl/rldt_read_plan.sv]
// read plan bound and final status into the response register
// depends on rldt_pkg
module rldt_read_plan
   import rldt_pkg::*;
(
   input  logic      clock,
   input  logic      load,
   input  shown_type shown,
   output rsp_type   rsp_ff
);

   rsp_type     rsp_in;
   logic [63:0] avail;
   logic        out_of_range;

   assign avail        = shown.tail_seq - shown.plan_first_seq;
   assign out_of_range = (shown.plan_first_seq < shown.head_seq) ||
                         (shown.plan_first_seq > shown.tail_seq);

   always_comb begin
      rsp_in.status          = shown.status;
      rsp_in.shown_read_seq  = shown.head_seq;
      rsp_in.shown_write_seq = shown.tail_seq;
      rsp_in.shown_dropped   = shown.dropped;
      rsp_in.unsafe_count    = shown.hidden;
      rsp_in.plan_count      = '0;
      rsp_in.terminal_flag   = shown.terminal_mark;
      if (shown.opcode == OP_PLAN) begin
         if (out_of_range) begin
            rsp_in.status = ST_RANGE;
         end else if (avail < {32'd0, shown.plan_limit}) begin
            rsp_in.plan_count = avail[31:0];
         end else begin
            rsp_in.plan_count = shown.plan_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[verif/ring_log_durability_tracker_tb.sv]
// self-checking bench for ring_log_durability_tracker: a directed command table,
// then random commands over several ring capacities, checked by a cursor predictor
// depends on rldt_pkg and the ring_log_durability_tracker rtl
`timescale 1ns / 100ps

module ring_log_durability_tracker_tb;
   import rldt_pkg::*;

   localparam opcode_type OpUnused6 = opcode_type'(3'd6);
   localparam opcode_type OpUnused7 = opcode_type'(3'd7);

   typedef struct {
      req_type cmd;
      logic    typed;
      rsp_type word;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   // predicted cursor state
   logic [31:0] ring_cap = CapacityReset;
   logic [63:0] cur_read = '0;
   logic [63:0] cur_write = '0;
   logic [63:0] cur_dropped = '0;
   logic [63:0] cur_unsafe_start = '0;
   logic        cur_unsafe = 1'b0;
   logic        cur_terminal = 1'b0;

   rsp_type      cursor_reports[$];
   step_row_type step_table[$];
   int           mismatches = 0;
   int           cmds_sent = 0;
   int           words_checked = 0;
   int           cap_settings = 0;
   int           req_gap_max = 10;
   int           rsp_gap_max = 10;
   int           rsp_hold_len = 0;

   always #2 clock = ~clock;

   ring_log_durability_tracker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic cursor_fits(logic [63:0] rd, logic [63:0] wr);
      return (wr >= rd) && ((wr - rd) <= {32'd0, ring_cap});
   endfunction

   function automatic void take_cursor(req_type c);
      cur_read = c.cand_read_seq;
      cur_write = c.cand_write_seq;
      cur_dropped = c.cand_dropped;
   endfunction

   // a read floor that moved past the durable one is kept even on failure
   function automatic void raise_floor(req_type c);
      if (c.cand_read_seq > cur_read) begin
         cur_read = c.cand_read_seq;
         cur_dropped = c.cand_dropped;
      end
   endfunction

   function automatic rsp_type apply_command(req_type c);
      rsp_type     r;
      status_type  st;
      logic [63:0] safe;
      logic [63:0] avail;
      r = '0;
      st = ST_OK;
      case (c.opcode)
         OP_MOUNT: begin
            if (!cursor_fits(c.cand_read_seq, c.cand_write_seq)) begin
               st = ST_INVALID;
            end else begin
               take_cursor(c);
               cur_unsafe_start = '0;
               cur_unsafe = 1'b0;
               cur_terminal = 1'b0;
            end
         end
         OP_BATCH: begin
            if (!cursor_fits(c.cand_read_seq, c.cand_write_seq) ||
                c.batch_first_seq > c.cand_write_seq) begin
               st = ST_INVALID;
            end else if (!c.write_ok) begin
               if (c.batch_first_seq < cur_write) begin
                  cur_unsafe_start = c.batch_first_seq;
                  cur_unsafe = 1'b1;
               end
               raise_floor(c);
               st = ST_WRITE_FAIL;
            end else begin
               cur_unsafe = 1'b0;
               cur_unsafe_start = '0;
               if (c.metadata_ok) begin
                  take_cursor(c);
               end else begin
                  raise_floor(c);
                  st = ST_META_FAIL;
               end
            end
         end
         OP_META: begin
            if (c.quarantined) begin
               st = ST_BUSY;
            end else if (!cursor_fits(c.cand_read_seq, c.cand_write_seq)) begin
               st = ST_INVALID;
            end else if (!c.metadata_ok) begin
               st = ST_META_FAIL;
            end else begin
               take_cursor(c);
            end
         end
         OP_TERMINAL: cur_terminal = 1'b1;
         OP_QUERY, OP_PLAN: ;
         default: st = ST_INVALID;
      endcase

      // advertised cursor: write end clamped to the unsafe start
      r.shown_read_seq = cur_read;
      r.shown_write_seq = cur_write;
      r.shown_dropped = cur_dropped;
      if (cur_unsafe) begin
         safe = cur_unsafe_start;
         if (safe < cur_read) begin
            safe = cur_read;
         end else if (safe > cur_write) begin
            safe = cur_write;
         end
         r.unsafe_count = cur_write - safe;
         r.shown_write_seq = safe;
         if (~cur_dropped < r.unsafe_count) begin
            r.shown_dropped = '1;
         end else begin
            r.shown_dropped = cur_dropped + r.unsafe_count;
         end
      end

      if (c.opcode == OP_PLAN) begin
         if (c.plan_first_seq < r.shown_read_seq ||
             c.plan_first_seq > r.shown_write_seq) begin
            st = ST_RANGE;
         end else begin
            avail = r.shown_write_seq - c.plan_first_seq;
            r.plan_count = (avail < {32'd0, c.plan_limit}) ? avail[31:0] : c.plan_limit;
         end
      end
      r.status = st;
      r.terminal_flag = cur_terminal;
      return r;
   endfunction

   // flags: {sync_asked, write_ok, metadata_ok, quarantined}
   function automatic req_type make_cmd(opcode_type op, logic [63:0] rd, logic [63:0] wr,
                                        logic [63:0] dr, logic [63:0] bs, logic [3:0] flags,
                                        logic [63:0] start, logic [31:0] maxp);
      req_type c;
      c.opcode = op;
      c.cand_read_seq = rd;
      c.cand_write_seq = wr;
      c.cand_dropped = dr;
      c.batch_first_seq = bs;
      {c.sync_asked, c.write_ok, c.metadata_ok, c.quarantined} = flags;
      c.plan_first_seq = start;
      c.plan_limit = maxp;
      return c;
   endfunction

   function automatic rsp_type make_word(status_type st, logic [63:0] rd, logic [63:0] wr,
                                         logic [63:0] dr, logic [63:0] hidden,
                                         logic [31:0] plan, logic term);
      rsp_type w;
      w.status = st;
      w.shown_read_seq = rd;
      w.shown_write_seq = wr;
      w.shown_dropped = dr;
      w.unsafe_count = hidden;
      w.plan_count = plan;
      w.terminal_flag = term;
      return w;
   endfunction

   function automatic void add_row(req_type cmd, logic typed, rsp_type word);
      step_row_type r;
      r.cmd = cmd;
      r.typed = typed;
      r.word = word;
      step_table.push_back(r);
   endfunction

   // candidates mostly move forward from the durable floor so commits land
   function automatic req_type random_cmd();
      req_type     c;
      int unsigned pick;
      logic [63:0] span;
      c = '0;
      pick = $urandom_range(0, 99);
      if (pick < 12) c.opcode = OP_MOUNT;
      else if (pick < 45) c.opcode = OP_BATCH;
      else if (pick < 65) c.opcode = OP_META;
      else if (pick < 69) c.opcode = OP_TERMINAL;
      else if (pick < 76) c.opcode = OP_QUERY;
      else if (pick < 97) c.opcode = OP_PLAN;
      else c.opcode = $urandom_range(0, 1) ? OpUnused6 : OpUnused7;

      case ($urandom_range(0, 9))
         0: c.cand_read_seq = rand64();
         1: c.cand_read_seq = '1 - $urandom_range(0, 70000);
         2: c.cand_read_seq = 64'($urandom_range(0, 100));
         default: c.cand_read_seq = cur_read + $urandom_range(0, 40);
      endcase
      case ($urandom_range(0, 9))
         0: span = {32'd0, ring_cap};
         1: span = {32'd0, ring_cap} + 64'd1;
         2: span = rand64();
         default: span = 64'($urandom_range(0, ring_cap < 2000 ? ring_cap : 2000));
      endcase
      c.cand_write_seq = c.cand_read_seq + span;
      case ($urandom_range(0, 9))
         0: c.batch_first_seq = rand64();
         1: c.batch_first_seq = c.cand_write_seq + 64'd1;
         default: c.batch_first_seq = c.cand_write_seq - $urandom_range(0, 3000);
      endcase
      case ($urandom_range(0, 5))
         0: c.cand_dropped = '1 - $urandom_range(0, 5000);
         1: c.cand_dropped = rand64();
         default: c.cand_dropped = cur_dropped + $urandom_range(0, 20);
      endcase
      c.sync_asked = 1'($urandom_range(0, 1));
      c.write_ok = $urandom_range(0, 9) < 7;
      c.metadata_ok = $urandom_range(0, 9) < 8;
      c.quarantined = $urandom_range(0, 9) < 2;
      case ($urandom_range(0, 7))
         0: c.plan_first_seq = rand64();
         1: c.plan_first_seq = cur_write;
         2: c.plan_first_seq = cur_read - 64'd1;
         default: c.plan_first_seq = cur_read + $urandom_range(0, 3000);
      endcase
      case ($urandom_range(0, 5))
         0: c.plan_limit = $urandom();
         1: c.plan_limit = '0;
         default: c.plan_limit = $urandom_range(0, 4000);
      endcase
      return c;
   endfunction

   task automatic send_cmd(req_type cmd, int gap, logic typed, rsp_type word);
      rsp_type predicted;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = apply_command(cmd);
      cursor_reports.push_back(typed ? word : predicted);
      cmds_sent++;
   endtask

   task automatic write_capacity(logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      ring_cap = value;
      cap_settings++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (cursor_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   task automatic check_report(rsp_type got);
      rsp_type want;
      if (cursor_reports.size() == 0) begin
         $error("result word with no command outstanding");
         mismatches++;
         return;
      end
      want = cursor_reports.pop_front();
      words_checked++;
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("shown_read_seq", want.shown_read_seq, got.shown_read_seq);
      compare_field("shown_write_seq", want.shown_write_seq, got.shown_write_seq);
      compare_field("shown_dropped", want.shown_dropped, got.shown_dropped);
      compare_field("unsafe_count", want.unsafe_count, got.unsafe_count);
      compare_field("plan_count", 64'(want.plan_count), 64'(got.plan_count));
      compare_field("terminal_flag", 64'(want.terminal_flag), 64'(got.terminal_flag));
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_hold_len > 0) begin
            gap = rsp_hold_len;
            rsp_hold_len = 0;
         end else begin
            gap = $urandom_range(0, rsp_gap_max);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         check_report(rsp_data);
      end
   end

   initial begin
      #2000000;
      $display("ring_log_durability_tracker test failed");
      $finish;
   end

   initial begin
      logic [31:0] cap;
      int          n;
      int          gap;
      logic [63:0] near_max;
      near_max = '1 - 64'd10;

      add_row(make_cmd(OP_QUERY, 0, 0, 0, 0, 4'b0000, 0, 0), 1'b1,
              make_word(ST_OK, 0, 0, 0, 0, 0, 1'b0));
      add_row(make_cmd(OP_PLAN, 0, 0, 0, 0, 4'b0000, 0, '1), 1'b1,
              make_word(ST_OK, 0, 0, 0, 0, 0, 1'b0));
      add_row(make_cmd(OP_PLAN, 0, 0, 0, 0, 4'b0000, 1, 10), 1'b1,
              make_word(ST_RANGE, 0, 0, 0, 0, 0, 1'b0));
      add_row(make_cmd(OpUnused6, 1, 2, 3, 4, 4'b1111, 5, 6), 1'b1,
              make_word(ST_INVALID, 0, 0, 0, 0, 0, 1'b0));
      add_row(make_cmd(OpUnused7, '1, '1, '1, '1, 4'b1111, '1, '1), 1'b1,
              make_word(ST_INVALID, 0, 0, 0, 0, 0, 1'b0));
      // read ahead of write, then a span one past the ring
      add_row(make_cmd(OP_MOUNT, 5, 4, 0, 0, 4'b0000, 0, 0), 1'b1,
              make_word(ST_INVALID, 0, 0, 0, 0, 0, 1'b0));
      add_row(make_cmd(OP_MOUNT, 0, 65537, 0, 0, 4'b0000, 0, 0), 1'b1,
              make_word(ST_INVALID, 0, 0, 0, 0, 0, 1'b0));
      add_row(make_cmd(OP_MOUNT, 100, 65636, 7, 0, 4'b0000, 0, 0), 1'b1,
              make_word(ST_OK, 100, 65636, 7, 0, 0, 1'b0));
      add_row(make_cmd(OP_TERMINAL, 0, 0, 0, 0, 4'b0000, 0, 0), 1'b1,
              make_word(ST_OK, 100, 65636, 7, 0, 0, 1'b1));
      add_row(make_cmd(OP_PLAN, 0, 0, 0, 0, 4'b0000, 200, 10), 1'b0, '0);
      add_row(make_cmd(OP_PLAN, 0, 0, 0, 0, 4'b0000, 65636, 5), 1'b0, '0);
      add_row(make_cmd(OP_BATCH, 100, 200, 0, 300, 4'b0110, 0, 0), 1'b1,
              make_word(ST_INVALID, 100, 65636, 7, 0, 0, 1'b1));
      // failed batch hides the tail and still moves the floor
      add_row(make_cmd(OP_BATCH, 150, 60100, 9, 60000, 4'b1010, 0, 0), 1'b0, '0);
      add_row(make_cmd(OP_QUERY, 0, 0, 0, 0, 4'b0000, 0, 0), 1'b0, '0);
      add_row(make_cmd(OP_META, 160, 60200, 11, 0, 4'b0011, 0, 0), 1'b0, '0);
      add_row(make_cmd(OP_META, 10, 5, 11, 0, 4'b0010, 0, 0), 1'b0, '0);
      add_row(make_cmd(OP_META, 160, 60200, 11, 0, 4'b1000, 0, 0), 1'b0, '0);
      add_row(make_cmd(OP_META, 160, 60200, 11, 0, 4'b0010, 170, 50), 1'b0, '0);
      add_row(make_cmd(OP_BATCH, 170, 60300, 12, 60250, 4'b0100, 0, 0), 1'b0, '0);
      add_row(make_cmd(OP_BATCH, 180, 60400, 13, 60300, 4'b1111, 0, 0), 1'b0, '0);
      add_row(make_cmd(OP_MOUNT, '1, '1, '1, 0, 4'b0000, 0, 0), 1'b1,
              make_word(ST_OK, '1, '1, '1, 0, 0, 1'b0));
      add_row(make_cmd(OP_MOUNT, 0, 65536, near_max, 0, 4'b0000, 0, 0), 1'b1,
              make_word(ST_OK, 0, 65536, near_max, 0, 0, 1'b0));
      // hidden packets push the dropped count to saturate at all ones
      add_row(make_cmd(OP_BATCH, 0, 0, 5, 0, 4'b0010, 0, 0), 1'b1,
              make_word(ST_WRITE_FAIL, 0, 0, '1, 65536, 0, 1'b0));
      // floor advance past the write end leaves the cursor inverted
      add_row(make_cmd(OP_BATCH, 70000, 70000, 3, 70000, 4'b0000, 0, 0), 1'b0, '0);
      add_row(make_cmd(OP_PLAN, 0, 0, 0, 0, 4'b0000, 68000, 100), 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (step_table[i]) begin
         send_cmd(step_table[i].cmd, $urandom_range(0, 10), step_table[i].typed,
                  step_table[i].word);
      end

      for (int p = 0; p < 5; p++) begin
         drain();
         case (p)
            0: begin cap = '0; n = 60; gap = 10; end
            1: begin cap = '1; n = 70; gap = 0; end
            2: begin cap = 32'd16; n = 100; gap = 10; end
            3: begin cap = CapacityReset; n = 90; gap = 4; end
            default: begin cap = $urandom_range(1, 100000); n = 80; gap = 10; end
         endcase
         write_capacity(cap);
         req_gap_max = gap;
         rsp_gap_max = gap;
         if (p == 3) begin
            // hold results back while commands keep coming, then let it all drain
            rsp_hold_len = 150;
            repeat (30) send_cmd(random_cmd(), 0, 1'b0, '0);
            drain();
         end
         repeat (n) send_cmd(random_cmd(), $urandom_range(0, req_gap_max), 1'b0, '0);
      end
      req_valid <= 1'b0;

      drain();
      $display("%0d commands over %0d written ring capacities, %0d result words checked",
               cmds_sent, cap_settings, words_checked);
      if (mismatches == 0) begin
         $display("ring_log_durability_tracker test passed");
      end else begin
         $display("ring_log_durability_tracker test failed");
      end
      $finish;
   end

endmodule

[ring_log_durability_tracker.f]
hw/rtl/rldt_pkg.sv
hw/rtl/rldt_cursor_update.sv
hw/rtl/rldt_shown_cursor.sv
hw/rtl/rldt_read_plan.sv
hw/rtl/ring_log_durability_tracker.sv
verif/ring_log_durability_tracker_tb.sv
